// ===== rtl/rbb_pkg.sv =====
package rbb_pkg;

  // One RGB pixel: red [7:0], green [15:8], blue [23:16]
  typedef logic [23:0] pix_t;

  localparam int CH_WIDTH  = 8;
  localparam int NUM_CH    = 3;

  // Config register indexes
  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  localparam int CFG_DATA_WIDTH = 12;
  localparam int IMG_W_BITS     = 11;
  localparam int IMG_H_BITS     = 12;
  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd1024;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 12'd768;

  // Request kinds on tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Window sum width: 9 * 255 fits in 12 bits
  localparam int SUM_WIDTH = 12;

  // floor(x / 9) == (x * 3641) >> 15 for all x < 32768
  localparam logic [SUM_WIDTH-1:0] DIV9_MUL = 12'd3641;
  localparam int DIV9_SHIFT = 15;

  // Output buffer
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic last;
    pix_t data;
  } out_word_t;

endpackage

// ===== rtl/rgb_box_blur_3x3.sv =====
// rgb_box_blur_3x3: 3x3 truncated-mean filter on an RGB raster stream.
// Throughput: one word per cycle on both sides, sustained while m_axis keeps up (the credit check drops s_axis_tready).
// Latency: a pixel's result leaves width+1 words after the pixel went in;
//   the result word reaches m_axis through stages 1 to 4 and the output buffer.
// Reset (rst, synchronous, active high): width 1024, height 768, position,
//   pending count, window and output buffer cleared; line store left as is.
module rgb_box_blur_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic        s_axis_tuser,   // req_type [0]: 0 pixel, 1 flush
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic        m_axis_tlast,   // frame_last
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  rbb_pkg::cfg_idx_t cfg_index,
  input  logic [rbb_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import rbb_pkg::*;

  // Width arithmetic holds the effective width itself
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > IMG_W_BITS) ?
                       $clog2(MAX_WIDTH + 1) : IMG_W_BITS;
  // Pending count reaches width + 1
  localparam int PW  = WCW + 1;
  // Line store address
  localparam int AW  = $clog2(MAX_WIDTH);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [IMG_W_BITS-1:0] img_width;
  logic [IMG_H_BITS-1:0] img_height;
  logic                  cfg_take;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width  <= IMG_W_RESET;
      img_height <= IMG_H_RESET;
    end else if (cfg_take) begin
      unique case (cfg_index)
        CFG_WIDTH:  img_width  <= cfg_data[IMG_W_BITS-1:0];
        CFG_HEIGHT: img_height <= cfg_data[IMG_H_BITS-1:0];
        default:    img_width  <= img_width;
      endcase
    end
  end

  // Effective frame size: zero acts as one, width clamps to MAX_WIDTH
  logic [WCW-1:0]        w_eff;
  logic [IMG_H_BITS-1:0] h_eff;

  always_comb begin
    if (img_width == '0) begin
      w_eff = WCW'(1);
    end else if (int'(img_width) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(img_width);
    end
    h_eff = (img_height == '0) ? IMG_H_BITS'(1) : img_height;
  end

  // ---------------------------------------------------------------------------
  // Front end: position tracking, done at accept time
  // ---------------------------------------------------------------------------
  logic [AW-1:0]         ring_ptr;
  logic [PW-1:0]         pend;
  logic [WCW-1:0]        col;
  logic [IMG_H_BITS-1:0] row;

  logic                  in_take;
  logic                  is_flush;
  logic                  shift_en;     // word moves the window
  logic                  emit_en;      // word releases a result
  logic [PW-1:0]         w_plus1;
  logic [WCW:0]          ptr_inc;
  logic [AW-1:0]         ring_ptr_next;
  logic [PW-1:0]         pend_next;
  logic                  interior;
  logic                  frame_end;
  logic [WCW-1:0]        col_next;
  logic [IMG_H_BITS-1:0] row_next;

  // credit check against the output buffer
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;
  logic                  s1_valid, s1_emit, s2_emit, s3_emit;

  assign occupancy = {1'b0, fifo_count} + (FIFO_CNT_W+1)'(s1_valid && s1_emit)
                   + (FIFO_CNT_W+1)'(s2_emit) + (FIFO_CNT_W+1)'(s3_emit);
  assign s_axis_tready = (occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH));

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign is_flush = (s_axis_tuser == REQ_FLUSH);
  assign w_plus1  = {1'b0, w_eff} + PW'(1);

  always_comb begin
    // idle flush does nothing at all
    shift_en = in_take && (!is_flush || pend != '0);
    emit_en  = shift_en && (is_flush || pend == w_plus1);

    ptr_inc       = {1'b0, WCW'(ring_ptr)} + (WCW+1)'(1);
    ring_ptr_next = (ptr_inc >= {1'b0, w_eff}) ? '0 : ring_ptr + 1'b1;

    if (is_flush) begin
      pend_next = pend - 1'b1;
    end else if (pend == w_plus1) begin
      pend_next = pend;
    end else begin
      pend_next = pend + 1'b1;
    end

    interior  = (row != '0) &&
                ({1'b0, row} + (IMG_H_BITS+1)'(1) < {1'b0, h_eff}) &&
                (col != '0) &&
                ({1'b0, col} + (WCW+1)'(1) < {1'b0, w_eff});
    frame_end = ({1'b0, row} + (IMG_H_BITS+1)'(1) >= {1'b0, h_eff}) &&
                ({1'b0, col} + (WCW+1)'(1) >= {1'b0, w_eff});

    col_next = col;
    row_next = row;
    if ({1'b0, col} + (WCW+1)'(1) >= {1'b0, w_eff}) begin
      col_next = '0;
      row_next = ({1'b0, row} + (IMG_H_BITS+1)'(1) >= {1'b0, h_eff}) ?
                 '0 : row + 1'b1;
    end else begin
      col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_take) begin
      ring_ptr <= '0;
      pend     <= '0;
      col      <= '0;
      row      <= '0;
    end else if (shift_en) begin
      ring_ptr <= ring_ptr_next;
      pend     <= pend_next;
      if (emit_en) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store read, forwarding for back-to-back same address
  // ---------------------------------------------------------------------------
  pix_t line0 [MAX_WIDTH];   // two rows back
  pix_t line1 [MAX_WIDTH];   // one row back
  pix_t rd0_q, rd1_q;
  pix_t rd0_eff, rd1_eff;

  logic          s1_interior, s1_last, s1_fwd;
  logic [AW-1:0] s1_addr;
  pix_t          s1_px;
  pix_t          fwd0, fwd1;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rd0_q <= line0[ring_ptr];
      rd1_q <= line1[ring_ptr];
    end
  end

  assign rd0_eff = s1_fwd ? fwd0 : rd0_q;
  assign rd1_eff = s1_fwd ? fwd1 : rd1_q;

  // rows move down one line: line1 -> line0, new pixel -> line1
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line0[s1_addr] <= rd1_eff;
      line1[s1_addr] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_emit  <= 1'b0;
    end else begin
      s1_valid <= shift_en;
      s1_emit  <= emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      s1_addr     <= ring_ptr;
      s1_px       <= is_flush ? '0 : s_axis_tdata;
      s1_interior <= interior;
      s1_last     <= frame_end;
      // read at this edge misses the write issued at this same edge
      s1_fwd      <= s1_valid && (s1_addr == ring_ptr);
      fwd0        <= rd1_eff;
      fwd1        <= s1_px;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: window update; win[column oldest..newest][row oldest..newest]
  // ---------------------------------------------------------------------------
  pix_t win [3][3];
  logic s2_interior, s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else if (s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[0][r] <= win[1][r];
        win[1][r] <= win[2][r];
      end
      win[2][0] <= rd0_eff;
      win[2][1] <= rd1_eff;
      win[2][2] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else begin
      s2_emit <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_interior <= s1_interior;
    s2_last     <= s1_last;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: per-channel window sums
  // ---------------------------------------------------------------------------
  logic [SUM_WIDTH-1:0] sum_c [NUM_CH];
  logic [SUM_WIDTH-1:0] s3_sum [NUM_CH];
  pix_t                 s3_center;
  logic                 s3_interior, s3_last;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_c[ch] = '0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          sum_c[ch] = sum_c[ch] +
                      SUM_WIDTH'(win[c][r][ch*CH_WIDTH +: CH_WIDTH]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
    end else begin
      s3_emit <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_emit) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s3_sum[ch] <= sum_c[ch];
      end
      s3_center   <= win[1][1];
      s3_interior <= s2_interior;
      s3_last     <= s2_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: divide by 9 via reciprocal, pick border/interior, into buffer
  // ---------------------------------------------------------------------------
  logic [2*SUM_WIDTH-1:0] prod [NUM_CH];
  out_word_t              res_word;

  always_comb begin
    res_word.last = s3_last;
    res_word.data = s3_center;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = s3_sum[ch] * DIV9_MUL;
      if (s3_interior) begin
        res_word.data[ch*CH_WIDTH +: CH_WIDTH] =
          prod[ch][DIV9_SHIFT +: CH_WIDTH];
      end
    end
  end

  out_word_t out_word;

  rbb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_emit),
    .push_word (res_word),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word),
    .count     (fifo_count)
  );

  assign m_axis_tdata = out_word.data;
  assign m_axis_tlast = out_word.last;

endmodule

// ===== rtl/rbb_fifo.sv =====
module rbb_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rbb_pkg::out_word_t push_word,
  output logic               out_valid,
  input  logic               out_ready,
  output rbb_pkg::out_word_t out_word,
  output logic [rbb_pkg::FIFO_CNT_W-1:0] count
);
  import rbb_pkg::*;

  out_word_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // push is only issued when the credit check leaves room
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sim/box_blur_checker.sv =====
// Watches the three channels of rgb_box_blur_3x3, keeps its own copy of the
// window, line store and frame position, and checks every output word in order.
module box_blur_checker
  import rbb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [23:0]               s_axis_tdata,
  input  logic                      s_axis_tuser,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [23:0]               m_axis_tdata,
  input  logic                      m_axis_tlast,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  cfg_idx_t                  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data,
  output int                        fail_count,
  output int                        results_owed
);

  localparam int unsigned WIN_TAPS = 9;

  pix_t line_old [MAX_WIDTH];   // two rows back
  pix_t line_new [MAX_WIDTH];   // one row back
  pix_t win [3][3];             // [column oldest..newest][row oldest..newest]

  int unsigned img_w, img_h;    // raw register values
  int unsigned row_pos, col_pos, held_px, ring;
  int          mismatches;
  out_word_t   owed_q [$];

  task automatic restart_frame();
    row_pos = 0;
    col_pos = 0;
    held_px = 0;
    ring    = 0;
  endtask

  task automatic shift_window(input pix_t px, input int unsigned w);
    int unsigned p;
    int c, r;
    p = (ring < w) ? ring : 0;
    for (c = 0; c < 2; c++)
      for (r = 0; r < 3; r++)
        win[c][r] = win[c+1][r];
    win[2][0] = line_old[p];
    win[2][1] = line_new[p];
    win[2][2] = px;
    line_old[p] = line_new[p];
    line_new[p] = px;
    ring = (p + 1 >= w) ? 0 : p + 1;
  endtask

  // Mean of the window for interior pixels, center pixel on the border.
  task automatic emit_pixel(input int unsigned w, input int unsigned h);
    out_word_t   o;
    logic        inner;
    int unsigned sum;
    int          c, r, ch;
    inner = row_pos >= 1 && row_pos + 1 < h && col_pos >= 1 && col_pos + 1 < w;
    for (ch = 0; ch < NUM_CH; ch++) begin
      if (inner) begin
        sum = 0;
        for (c = 0; c < 3; c++)
          for (r = 0; r < 3; r++)
            sum += win[c][r][CH_WIDTH*ch +: CH_WIDTH];
        o.data[CH_WIDTH*ch +: CH_WIDTH] = sum / WIN_TAPS;
      end else begin
        o.data[CH_WIDTH*ch +: CH_WIDTH] = win[1][1][CH_WIDTH*ch +: CH_WIDTH];
      end
    end
    o.last = (row_pos + 1 >= h) && (col_pos + 1 >= w);
    owed_q.push_back(o);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track
    int unsigned w, h;
    out_word_t   want;
    if (rst) begin
      img_w = IMG_W_RESET;
      img_h = IMG_H_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_old[i] = '0;
        line_new[i] = '0;
      end
      win = '{default: '0};
      restart_frame();
      owed_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_q.size() == 0) begin
          $error("output word %h (last %b) with nothing expected", m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = owed_q.pop_front();
          check_field("red_out",    want.data[7:0],   m_axis_tdata[7:0]);
          check_field("green_out",  want.data[15:8],  m_axis_tdata[15:8]);
          check_field("blue_out",   want.data[23:16], m_axis_tdata[23:16]);
          check_field("frame_last", want.last,        m_axis_tlast);
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  img_w = cfg_data[IMG_W_BITS-1:0];
          CFG_HEIGHT: img_h = cfg_data[IMG_H_BITS-1:0];
        endcase
        restart_frame();
      end

      if (s_axis_tvalid && s_axis_tready) begin
        w = (img_w == 0) ? 1 : ((img_w > MAX_WIDTH) ? MAX_WIDTH : img_w);
        h = (img_h == 0) ? 1 : img_h;
        if (s_axis_tuser == REQ_PIXEL) begin
          shift_window(s_axis_tdata, w);
          held_px++;
          if (held_px > w + 1) begin
            held_px = w + 1;
            emit_pixel(w, h);
          end
        end else if (held_px != 0) begin
          // flush: zero pixel into the window, oldest pending pixel out
          shift_window('0, w);
          held_px--;
          emit_pixel(w, h);
        end
      end
    end
    fail_count   <= mismatches;
    results_owed <= owed_q.size();
  end

endmodule

// ===== sim/rgb_box_blur_3x3_test.sv =====
// Top of the box blur testbench: clock, reset, input and config stimulus,
// output back-pressure and the verdict. All prediction and comparison lives
// in box_blur_checker, which only watches the ports.
module rgb_box_blur_3x3_test;
  import rbb_pkg::*;

  localparam int unsigned MAX_W          = 1024;
  localparam int unsigned IDLE_PCT       = 6;       // percent chance of an idle gap, both sides
  localparam int unsigned HOLD_CYCLES    = 400;     // one long output stall
  localparam int unsigned SETTLE_CYCLES  = 16;      // settle time after the last predicted result
  localparam int unsigned RANDOM_WORDS   = 2000;
  localparam int unsigned MAX_FRAME_PX   = 400;     // cap on pixels per random frame
  localparam int          CYCLE_LIMIT    = 200000;

  // shapes of a random phase
  typedef enum int {SEQ_CLEAN, SEQ_EARLY_FLUSH, SEQ_NOISE} seq_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [23:0]               s_axis_tdata  = '0;
  logic                      s_axis_tuser  = REQ_PIXEL;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [23:0]               m_axis_tdata;
  logic                      m_axis_tlast;
  logic                      cfg_valid     = 1'b0;
  logic                      cfg_ready;
  cfg_idx_t                  cfg_index     = CFG_WIDTH;
  logic [CFG_DATA_WIDTH-1:0] cfg_data      = '0;

  int   fail_count;
  int   results_owed;
  int   cycle_count = 0;
  int   words_sent  = 0;
  logic calm        = 1'b0;   // no idling on either side while set
  logic held        = 1'b0;
  int   hold_left   = 0;

  rgb_box_blur_3x3 #(
    .MAX_WIDTH (MAX_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  box_blur_checker #(
    .MAX_WIDTH (MAX_W)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hang anywhere (missing result, stuck ready) ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side. The first output word triggers one long stall so the output
  // buffer fills and s_axis_tready has to drop; after that, random ready
  // gaps except during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!held && m_axis_tvalid) begin
      held          <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic pix_t rand_pixel();
    pix_t px;
    int   ch;
    px = $urandom();
    // now and then push channels to the rails so sums hit 0 and 9*255
    if ($urandom_range(99) < 15)
      for (ch = 0; ch < NUM_CH; ch++)
        px[CH_WIDTH*ch +: CH_WIDTH] = $urandom_range(1) ? 8'hFF : 8'h00;
    return px;
  endfunction

  // One input word; random idle cycles first, then hold until accepted.
  // tready is sampled right after the edge, i.e. the value the edge saw.
  task automatic send_word(input logic req, input pix_t px);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
  endtask

  // Stop sending and wait for every predicted result, then give the
  // pipeline time to finish words that release nothing.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write so
  // back-to-back writes never schedule two updates in one step.
  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_WIDTH-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Both registers, only while idle. Each write restarts the frame.
  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input logic height_first);
    drain_results();
    if (height_first) begin
      write_reg(CFG_HEIGHT, h);
      write_reg(CFG_WIDTH, w);
    end else begin
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned req_w, req_h, eff_w, eff_h;
    int unsigned npx, nframes, nflush, sent_px, cut, k, f, pick, phase_no, stop_at;
    seq_style_t  style;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Warm-up: widest line (register above the maximum, so it clamps) and
    // two rows. Fills every line store entry before anything reads it back,
    // gives one full frame at maximum width, and the first output word here
    // sets off the long output stall. The last flush finds nothing pending.
    set_geometry(2047, 2, 1'b0);
    for (k = 0; k < 2 * MAX_W; k++) send_word(REQ_PIXEL, rand_pixel());
    for (k = 0; k < MAX_W + 2; k++) send_word(REQ_FLUSH, rand_pixel());

    // Zero width and height behave as 1: single-pixel frames, all border,
    // every word flagged last. All-zero and all-one pixels; idle flush.
    set_geometry(0, 0, 1'b0);
    send_word(REQ_PIXEL, 24'h000000);
    send_word(REQ_PIXEL, 24'hFFFFFF);
    repeat (3) send_word(REQ_FLUSH, 24'h000000);

    // Smallest frame with an interior: 3x3 of white around a black center,
    // center mean 8*255/9 truncates to 226 on every channel.
    set_geometry(3, 3, 1'b1);
    for (k = 0; k < 9; k++) send_word(REQ_PIXEL, (k == 4) ? 24'h000000 : 24'hFFFFFF);
    repeat (4) send_word(REQ_FLUSH, 24'hFFFFFF);

    // Width at MAX_W, height register at its maximum, frame cut short by flushes.
    set_geometry(MAX_W, 4095, 1'b0);
    repeat (3) send_word(REQ_PIXEL, rand_pixel());
    repeat (2) send_word(REQ_FLUSH, rand_pixel());

    // Random phases: mostly whole frames back to back followed by a flush
    // train, some with a flush inside the frame, some with random request
    // kinds. A middle stretch runs with no idling on either side.
    req_w    = MAX_W;
    req_h    = 4095;
    phase_no = 0;
    stop_at  = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      calm <= (phase_no >= 12 && phase_no < 24);

      // new geometry most of the time; otherwise keep going in the old frame
      if (phase_no == 0 || $urandom_range(99) < 85) begin
        pick = $urandom_range(99);
        if (pick < 3)       req_w = 0;
        else if (pick < 60) req_w = $urandom_range(6, 1);
        else if (pick < 85) req_w = $urandom_range(24, 7);
        else if (pick < 99) req_w = $urandom_range(120, 25);
        else                req_w = $urandom_range(2047, 900);
        pick = $urandom_range(99);
        if (pick < 8)       req_h = 0;
        else if (pick < 80) req_h = $urandom_range(6, 1);
        else if (pick < 95) req_h = $urandom_range(16, 7);
        else                req_h = $urandom_range(4095, 17);
        set_geometry(req_w, req_h, $urandom_range(1));
      end
      eff_w = (req_w == 0) ? 1 : ((req_w > MAX_W) ? MAX_W : req_w);
      eff_h = (req_h == 0) ? 1 : req_h;

      npx     = eff_w * eff_h;
      nframes = $urandom_range(3, 1);
      if (npx > MAX_FRAME_PX) begin
        // too big to finish: send part of one frame, flushed early
        npx     = $urandom_range(MAX_FRAME_PX, 1);
        nframes = 1;
      end

      pick = $urandom_range(99);
      if (pick < 80)      style = SEQ_CLEAN;
      else if (pick < 90) style = SEQ_EARLY_FLUSH;
      else                style = SEQ_NOISE;

      sent_px = 0;
      for (f = 0; f < nframes; f++) begin
        if (f != 0 && $urandom_range(99) < 15) drain_results();
        cut = $urandom_range(npx - 1);
        for (k = 0; k < npx; k++) begin
          if (style == SEQ_EARLY_FLUSH && k == cut) send_word(REQ_FLUSH, rand_pixel());
          if (style == SEQ_NOISE) begin
            send_word($urandom_range(1) ? REQ_FLUSH : REQ_PIXEL, rand_pixel());
          end else begin
            send_word(REQ_PIXEL, rand_pixel());
          end
          sent_px++;
        end
      end

      // sender pause before the flush train, guaranteed once
      if (phase_no == 1 || $urandom_range(99) < 10) drain_results();

      // enough flushes to empty the pipe plus up to two idle ones;
      // sometimes too few, leaving pixels behind for the next phase
      nflush = ((sent_px < eff_w + 1) ? sent_px : eff_w + 1) + $urandom_range(2);
      if ($urandom_range(99) < 8) nflush = $urandom_range(nflush);
      for (k = 0; k < nflush; k++) send_word(REQ_FLUSH, rand_pixel());

      phase_no++;
    end

    drain_results();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rbb_pkg.sv
rtl/rbb_fifo.sv
rtl/rgb_box_blur_3x3.sv
sim/box_blur_checker.sv
sim/rgb_box_blur_3x3_test.sv
